// ----- hw/rtl/dda_pkg.sv -----
// dda_pkg: shared constants, payload structs and command codes for the DDA line rasterizer.
// No dependencies; used by every module in hw/rtl.
package dda_pkg;

    // Widths and fixed-point format
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS   = FRAC_BITS + 2;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(FRAC_BITS);
    localparam int COLOR_BITS = 24;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hB3B3B3;

    // Work queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    // Input transfer payload
    typedef struct packed
    {
        cmd_t   cmd;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } cmd_item_t;

    // Output transfer payload
    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } pix_item_t;

    // Classified work entry held in the queue
    typedef struct packed
    {
        cmd_t   kind;
        coord_t x_start;
        coord_t y_start;
        coord_t dx_mag;
        coord_t dy_mag;
        coord_t steps;
        logic   x_neg;
        logic   y_neg;
    } work_t;

    // Queue status seen by front and back
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/dda_line_rasterizer_unit.sv -----
// DDA line rasterizer top level: front classifier, 4-entry work queue, back executor.
// Step transfer: pixel registered when the back pops it; one per cycle unless the output
// stalls or a load divides. Load transfer: no result; holds the back while the bit-serial
// divider runs (one quotient bit per cycle per axis). Up to 4 transfers queue meanwhile.
// Reset (rst_n, async, active low): idle, queue empty, line_color = 0xB3B3B3.
// Depends on dda_pkg, dda_front, dda_queue, dda_back.
module dda_line_rasterizer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dda_pkg::COLOR_BITS-1:0] cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  dda_pkg::cmd_item_t            cmd_item,
    output logic                          pix_valid,
    input  logic                          pix_stall,
    output dda_pkg::pix_item_t            pix_item
);

    dda_pkg::color_t    line_color_reg;
    dda_pkg::q_status_t q_status;
    dda_pkg::work_t     push_item;
    dda_pkg::work_t     head;
    logic               push;
    logic               pop;

    // Color register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_color_reg <= dda_pkg::COLOR_RESET;
        end
        else if (cfg_we)
        begin
            line_color_reg <= cfg_wdata;
        end
    end

    dda_front u_front
    (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    dda_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    dda_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .line_color (line_color_reg),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_item   (pix_item)
    );

endmodule

// ----- hw/rtl/dda_front.sv -----
// dda_front: accepts command transfers and classifies them into work entries
// (deltas, directions, step count). Depends on dda_pkg.
module dda_front
(
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  dda_pkg::cmd_item_t cmd_item,
    input  dda_pkg::q_status_t q_status,
    output logic               push,
    output dda_pkg::work_t     push_item
);

    dda_pkg::coord_t dx_mag;
    dda_pkg::coord_t dy_mag;
    logic            x_neg;
    logic            y_neg;

    // Absolute deltas and direction
    always_comb
    begin
        x_neg  = cmd_item.x_end < cmd_item.x_start;
        y_neg  = cmd_item.y_end < cmd_item.y_start;
        dx_mag = x_neg ? (cmd_item.x_start - cmd_item.x_end)
                       : (cmd_item.x_end - cmd_item.x_start);
        dy_mag = y_neg ? (cmd_item.y_start - cmd_item.y_end)
                       : (cmd_item.y_end - cmd_item.y_start);
    end

    // Build the queue entry; step count is the larger delta
    always_comb
    begin
        push_item.kind    = cmd_item.cmd;
        push_item.x_start = cmd_item.x_start;
        push_item.y_start = cmd_item.y_start;
        push_item.dx_mag  = dx_mag;
        push_item.dy_mag  = dy_mag;
        push_item.steps   = (dx_mag > dy_mag) ? dx_mag : dy_mag;
        push_item.x_neg   = x_neg;
        push_item.y_neg   = y_neg;
    end

    // Transfer happens whenever the queue has room
    assign cmd_stall = q_status.full;
    assign push      = cmd_valid && !q_status.full;

endmodule

// ----- hw/rtl/dda_queue.sv -----
// dda_queue: small FIFO of classified work entries between front and back.
// Depends on dda_pkg.
module dda_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dda_pkg::work_t     push_item,
    input  logic               pop,
    output dda_pkg::work_t     head,
    output dda_pkg::q_status_t q_status
);

    dda_pkg::work_t                 entries [dda_pkg::FIFO_DEPTH];
    logic [dda_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [dda_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [dda_pkg::FIFO_AW:0]      count_reg;
    logic [dda_pkg::FIFO_AW:0]      count_next;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head           = entries[rd_ptr_reg];
    assign q_status.full  = count_reg == (dda_pkg::FIFO_AW+1)'(dda_pkg::FIFO_DEPTH);
    assign q_status.empty = count_reg == '0;

endmodule

// ----- hw/rtl/dda_back.sv -----
// dda_back: executes queued work: iterative increment division on loads,
// position stepping and the registered pixel output. Depends on dda_pkg.
module dda_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  dda_pkg::work_t     head,
    input  dda_pkg::q_status_t q_status,
    output logic               pop,
    input  dda_pkg::color_t    line_color,
    output logic               pix_valid,
    input  logic               pix_stall,
    output dda_pkg::pix_item_t pix_item
);

    typedef enum logic
    {
        ST_RUN,
        ST_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [dda_pkg::POS_BITS-1:0]          pos_x_reg, pos_x_next;
    logic [dda_pkg::POS_BITS-1:0]          pos_y_reg, pos_y_next;
    logic signed [dda_pkg::INC_BITS-1:0]   inc_x_reg, inc_x_next;
    logic signed [dda_pkg::INC_BITS-1:0]   inc_y_reg, inc_y_next;
    dda_pkg::coord_t                       steps_left_reg, steps_left_next;

    // Divider state
    dda_pkg::coord_t                       dvs_reg, dvs_next;
    dda_pkg::coord_t                       rem_x_reg, rem_x_next;
    dda_pkg::coord_t                       rem_y_reg, rem_y_next;
    logic [dda_pkg::QUO_BITS-1:0]          quo_x_reg, quo_x_next;
    logic [dda_pkg::QUO_BITS-1:0]          quo_y_reg, quo_y_next;
    logic [dda_pkg::CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                                  neg_x_reg, neg_x_next;
    logic                                  neg_y_reg, neg_y_next;

    logic                                  pix_valid_reg, pix_valid_next;
    dda_pkg::pix_item_t                    pix_item_reg, pix_item_next;

    logic                                  out_free;
    logic                                  x_whole;
    logic                                  y_whole;
    logic [dda_pkg::COORD_BITS:0]          trial_x;
    logic [dda_pkg::COORD_BITS:0]          trial_y;
    logic                                  ge_x;
    logic                                  ge_y;

    // One restoring-division step per cycle for each axis
    always_comb
    begin
        trial_x = {rem_x_reg, 1'b0};
        trial_y = {rem_y_reg, 1'b0};
        ge_x    = trial_x >= {1'b0, dvs_reg};
        ge_y    = trial_y >= {1'b0, dvs_reg};
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_left_next = steps_left_reg;
        dvs_next        = dvs_reg;
        rem_x_next      = rem_x_reg;
        rem_y_next      = rem_y_reg;
        quo_x_next      = quo_x_reg;
        quo_y_next      = quo_y_reg;
        cnt_next        = cnt_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        pix_valid_next  = pix_valid_reg;
        pix_item_next   = pix_item_reg;
        pop             = 1'b0;

        // delta never exceeds the step count, so the integer part is 0 or 1
        x_whole  = head.dx_mag == head.steps;
        y_whole  = head.dy_mag == head.steps;
        out_free = !pix_valid_reg || !pix_stall;

        if (pix_valid_reg && !pix_stall)
        begin
            pix_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (!q_status.empty)
                begin
                    if (head.kind == dda_pkg::CMD_LOAD)
                    begin
                        // New line: latch start and set up the division
                        pop             = 1'b1;
                        pos_x_next      = {head.x_start, {dda_pkg::FRAC_BITS{1'b0}}};
                        pos_y_next      = {head.y_start, {dda_pkg::FRAC_BITS{1'b0}}};
                        steps_left_next = head.steps;
                        dvs_next        = head.steps;
                        neg_x_next      = head.x_neg;
                        neg_y_next      = head.y_neg;
                        rem_x_next      = x_whole ? '0 : head.dx_mag;
                        rem_y_next      = y_whole ? '0 : head.dy_mag;
                        quo_x_next      = dda_pkg::QUO_BITS'(x_whole);
                        quo_y_next      = dda_pkg::QUO_BITS'(y_whole);
                        cnt_next        = '0;
                        if (head.steps == '0)
                        begin
                            inc_x_next = '0;
                            inc_y_next = '0;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else if (steps_left_reg == '0)
                    begin
                        // Step with no line in progress: dropped
                        pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        // Emit current pixel, then advance
                        pop                       = 1'b1;
                        pix_valid_next            = 1'b1;
                        pix_item_next.pixel_x     =
                            pos_x_reg[dda_pkg::POS_BITS-1 -: dda_pkg::COORD_BITS];
                        pix_item_next.pixel_y     =
                            pos_y_reg[dda_pkg::POS_BITS-1 -: dda_pkg::COORD_BITS];
                        pix_item_next.pixel_color = line_color;
                        pix_item_next.last_pixel  = steps_left_reg == dda_pkg::COORD_BITS'(1);
                        pos_x_next      = pos_x_reg + dda_pkg::POS_BITS'(inc_x_reg);
                        pos_y_next      = pos_y_reg + dda_pkg::POS_BITS'(inc_y_reg);
                        steps_left_next = steps_left_reg - 1'b1;
                    end
                end
            end

            ST_DIV:
            begin
                rem_x_next = ge_x ? dda_pkg::COORD_BITS'(trial_x - {1'b0, dvs_reg})
                                  : trial_x[dda_pkg::COORD_BITS-1:0];
                rem_y_next = ge_y ? dda_pkg::COORD_BITS'(trial_y - {1'b0, dvs_reg})
                                  : trial_y[dda_pkg::COORD_BITS-1:0];
                quo_x_next = {quo_x_reg[dda_pkg::QUO_BITS-2:0], ge_x};
                quo_y_next = {quo_y_reg[dda_pkg::QUO_BITS-2:0], ge_y};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == dda_pkg::CNT_BITS'(dda_pkg::FRAC_BITS - 1))
                begin
                    // Last fraction bit: apply the direction and finish
                    inc_x_next = neg_x_reg ? -dda_pkg::INC_BITS'(quo_x_next)
                                           : dda_pkg::INC_BITS'(quo_x_next);
                    inc_y_next = neg_y_reg ? -dda_pkg::INC_BITS'(quo_y_next)
                                           : dda_pkg::INC_BITS'(quo_y_next);
                    state_next = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            dvs_reg        <= '0;
            rem_x_reg      <= '0;
            rem_y_reg      <= '0;
            quo_x_reg      <= '0;
            quo_y_reg      <= '0;
            cnt_reg        <= '0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            pix_valid_reg  <= 1'b0;
            pix_item_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            steps_left_reg <= steps_left_next;
            dvs_reg        <= dvs_next;
            rem_x_reg      <= rem_x_next;
            rem_y_reg      <= rem_y_next;
            quo_x_reg      <= quo_x_next;
            quo_y_reg      <= quo_y_next;
            cnt_reg        <= cnt_next;
            neg_x_reg      <= neg_x_next;
            neg_y_reg      <= neg_y_next;
            pix_valid_reg  <= pix_valid_next;
            pix_item_reg   <= pix_item_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_item  = pix_item_reg;

    // Checks
    a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> !pop)
        else $error("queue popped while dividing");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dvs_reg != '0)
        else $error("division by zero step count");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == dda_pkg::CMD_STEP
            && steps_left_reg == dda_pkg::COORD_BITS'(1)) |=> steps_left_reg == '0)
        else $error("line did not end after last pixel");

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for dda_line_rasterizer_unit (line setup and pixel stepping).
// Depends on dda_pkg and the rasterizer RTL; drives commands, predicts pixels, checks results.
// Directed table first, then random line bursts under several colors and idle patterns.
module tb_top;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 100;     // four queued loads finishing their division, plus slack
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 350;

    typedef logic signed [dda_pkg::INC_BITS-1:0] slope_t;

    // One row of the directed table; typed rows carry their own expected outcome
    typedef struct {
        dda_pkg::cmd_item_t item;
        bit                 typed;
        bit                 has_pix;
        dda_pkg::pix_item_t pix;
    } vector_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    dda_pkg::color_t    cfg_wdata;
    logic               cmd_valid;
    logic               cmd_stall;
    dda_pkg::cmd_item_t cmd_item;
    logic               pix_valid;
    logic               pix_stall;
    dda_pkg::pix_item_t pix_item;

    // Predictor state
    logic [dda_pkg::POS_BITS-1:0] trace_x = '0;
    logic [dda_pkg::POS_BITS-1:0] trace_y = '0;
    slope_t                       slope_x = '0;
    slope_t                       slope_y = '0;
    dda_pkg::coord_t              pixels_left = '0;
    dda_pkg::color_t              cur_color = dda_pkg::COLOR_RESET;

    dda_pkg::pix_item_t pending_pixels[$];
    vector_t            dir_tab[$];
    int                 bad_pixels = 0;
    int                 cycle_cnt = 0;
    int                 gap_pct = 25;
    int                 stall_pct = 25;
    int                 stall_hold = 0;

    dda_line_rasterizer_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item)
    );

    always #HALF_PERIOD clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver back-pressure: mostly short stalls, a few long ones
    always @(negedge clk)
    begin
        if (stall_hold > 0)
            stall_hold = stall_hold - 1;
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            pix_stall <= 1'b1;
            stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
        end
        else
            pix_stall <= 1'b0;
    end

    // Signed per-step increment, truncated toward zero
    function automatic slope_t slope_of(input dda_pkg::coord_t s, input dda_pkg::coord_t e,
                                        input dda_pkg::coord_t n);
        logic [dda_pkg::POS_BITS-1:0] mag;
        logic [dda_pkg::POS_BITS-1:0] q;
        mag = dda_pkg::POS_BITS'((e >= s) ? e - s : s - e);
        q   = (mag << dda_pkg::FRAC_BITS) / dda_pkg::POS_BITS'(n);
        return (e >= s) ? q[dda_pkg::INC_BITS-1:0] : -q[dda_pkg::INC_BITS-1:0];
    endfunction

    // Advance the line tracer by one command; returns 1 when a pixel comes out
    function automatic bit trace_line(input dda_pkg::cmd_item_t it,
                                      output dda_pkg::pix_item_t px);
        dda_pkg::coord_t dx;
        dda_pkg::coord_t dy;
        dda_pkg::coord_t n;
        px = '0;
        if (it.cmd == dda_pkg::CMD_LOAD)
        begin
            dx = (it.x_end >= it.x_start) ? it.x_end - it.x_start : it.x_start - it.x_end;
            dy = (it.y_end >= it.y_start) ? it.y_end - it.y_start : it.y_start - it.y_end;
            n  = (dx > dy) ? dx : dy;
            trace_x     = {it.x_start, {dda_pkg::FRAC_BITS{1'b0}}};
            trace_y     = {it.y_start, {dda_pkg::FRAC_BITS{1'b0}}};
            slope_x     = (n == 0) ? '0 : slope_of(it.x_start, it.x_end, n);
            slope_y     = (n == 0) ? '0 : slope_of(it.y_start, it.y_end, n);
            pixels_left = n;
            return 1'b0;
        end
        if (pixels_left == 0)
            return 1'b0;
        px.pixel_x     = trace_x[dda_pkg::POS_BITS-1:dda_pkg::FRAC_BITS];
        px.pixel_y     = trace_y[dda_pkg::POS_BITS-1:dda_pkg::FRAC_BITS];
        px.pixel_color = cur_color;
        px.last_pixel  = (pixels_left == 1);
        trace_x     = trace_x + {{(dda_pkg::POS_BITS-dda_pkg::INC_BITS){slope_x[dda_pkg::INC_BITS-1]}},
                                 slope_x};
        trace_y     = trace_y + {{(dda_pkg::POS_BITS-dda_pkg::INC_BITS){slope_y[dda_pkg::INC_BITS-1]}},
                                 slope_y};
        pixels_left = pixels_left - 1'b1;
        return 1'b1;
    endfunction

    // Output checker: every accepted pixel against the oldest pending one
    always @(posedge clk)
    begin
        dda_pkg::pix_item_t want;
        if (rst_n === 1'b1 && pix_valid === 1'b1 && pix_stall === 1'b0)
        begin
            if (pending_pixels.size() == 0)
            begin
                bad_pixels = bad_pixels + 1;
                if (bad_pixels <= 10)
                    $display("unexpected pixel: x=%0d y=%0d color=%06h last=%0b",
                             pix_item.pixel_x, pix_item.pixel_y,
                             pix_item.pixel_color, pix_item.last_pixel);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_item.pixel_x !== want.pixel_x || pix_item.pixel_y !== want.pixel_y ||
                    pix_item.pixel_color !== want.pixel_color ||
                    pix_item.last_pixel !== want.last_pixel)
                begin
                    bad_pixels = bad_pixels + 1;
                    if (bad_pixels <= 10)
                        $display("pixel mismatch: got x=%0d y=%0d color=%06h last=%0b, %s",
                                 pix_item.pixel_x, pix_item.pixel_y, pix_item.pixel_color,
                                 pix_item.last_pixel,
                                 $sformatf("expected x=%0d y=%0d color=%06h last=%0b",
                                           want.pixel_x, want.pixel_y, want.pixel_color,
                                           want.last_pixel));
                end
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic dda_pkg::cmd_item_t rand_item(input dda_pkg::cmd_t c);
        dda_pkg::cmd_item_t it;
        it.cmd     = c;
        it.x_start = dda_pkg::coord_t'($urandom_range(0, 1023));
        it.y_start = dda_pkg::coord_t'($urandom_range(0, 1023));
        it.x_end   = dda_pkg::coord_t'($urandom_range(0, 1023));
        it.y_end   = dda_pkg::coord_t'($urandom_range(0, 1023));
        return it;
    endfunction

    // Endpoint a few pixels from c, kept on screen
    function automatic dda_pkg::coord_t near(input dda_pkg::coord_t c);
        int v;
        v = int'(c) + $urandom_range(0, 16) - 8;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return dda_pkg::coord_t'(v);
    endfunction

    // Drive one command transfer, then book its expected pixel
    task automatic send_cmd(input dda_pkg::cmd_item_t it, input bit typed, input bit typed_has,
                            input dda_pkg::pix_item_t typed_pix, output bit live);
        int                 gap;
        bit                 got;
        dda_pkg::pix_item_t px;
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall !== 1'b0) @(posedge clk);
        got  = trace_line(it, px);
        live = (it.cmd == dda_pkg::CMD_LOAD) || got;
        if (typed)
        begin
            got = typed_has;
            px  = typed_pix;
        end
        if (got)
            pending_pixels.push_back(px);
    endtask

    // Hold off the sender until every pixel is in, then wait DRAIN_CYCLES for queued loads to finish
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_color(input dda_pkg::color_t c);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_color = c;
    endtask

    // Random line bursts: mostly whole lines, some overrun or cut short, some noise
    task automatic run_phase(input int quota, input bit hold_mid);
        int                 done;
        int                 n;
        int                 run;
        int                 dx;
        int                 dy;
        int                 pick;
        bit                 live;
        bit                 paused;
        dda_pkg::cmd_item_t it;
        dda_pkg::pix_item_t nopix;
        done   = 0;
        paused = 1'b0;
        nopix  = '0;
        while (done < quota)
        begin
            if (hold_mid && !paused && done >= quota / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 10)
            begin
                send_cmd(rand_item(dda_pkg::cmd_t'($urandom_range(0, 1))), 1'b0, 1'b0, nopix,
                         live);
                done = done + live;
            end
            else
            begin
                it = rand_item(dda_pkg::CMD_LOAD);
                if ($urandom_range(0, 4) != 0)
                begin
                    it.x_end = near(it.x_start);
                    it.y_end = near(it.y_start);
                end
                dx = (it.x_end > it.x_start) ? int'(it.x_end) - int'(it.x_start)
                                             : int'(it.x_start) - int'(it.x_end);
                dy = (it.y_end > it.y_start) ? int'(it.y_end) - int'(it.y_start)
                                             : int'(it.y_start) - int'(it.y_end);
                n  = (dx > dy) ? dx : dy;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    run = n;
                else if (pick < 85)
                    run = n + $urandom_range(1, 3);
                else
                    run = (n == 0) ? 0 : $urandom_range(0, n - 1);
                if (run > 48 && $urandom_range(0, 39) != 0)
                    run = $urandom_range(1, 48);
                send_cmd(it, 1'b0, 1'b0, nopix, live);
                done = done + live;
                repeat (run)
                begin
                    send_cmd(rand_item(dda_pkg::CMD_STEP), 1'b0, 1'b0, nopix, live);
                    done = done + live;
                end
            end
        end
    endtask

    function automatic vector_t load_row(input int xs, input int ys, input int xe, input int ye);
        vector_t r;
        r.item    = '{dda_pkg::CMD_LOAD, dda_pkg::coord_t'(xs), dda_pkg::coord_t'(ys),
                      dda_pkg::coord_t'(xe), dda_pkg::coord_t'(ye)};
        r.typed   = 1'b1;
        r.has_pix = 1'b0;
        r.pix     = '0;
        return r;
    endfunction

    // Step with no pixel, fields all ones
    function automatic vector_t idle_row();
        vector_t r;
        r.item    = '{dda_pkg::CMD_STEP, '1, '1, '1, '1};
        r.typed   = 1'b1;
        r.has_pix = 1'b0;
        r.pix     = '0;
        return r;
    endfunction

    function automatic vector_t pixel_row(input int x, input int y, input bit last);
        vector_t r;
        r.item    = '{dda_pkg::CMD_STEP, '0, '0, '0, '0};
        r.typed   = 1'b1;
        r.has_pix = 1'b1;
        r.pix     = '{dda_pkg::coord_t'(x), dda_pkg::coord_t'(y), dda_pkg::COLOR_RESET, last};
        return r;
    endfunction

    function automatic vector_t step_row();
        vector_t r;
        r = pixel_row(0, 0, 1'b0);
        r.typed = 1'b0;
        return r;
    endfunction

    initial
    begin
        bit              live;
        dda_pkg::color_t c;
        vector_t         v;
        int              phase_gap[PHASES];
        int              phase_stall[PHASES];

        phase_gap   = '{0, 30, 60, 10, 40};
        phase_stall = '{0, 30, 10, 70, 40};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle step, short line, zero-length line, extremes, line replaced
        dir_tab.push_back(idle_row());
        dir_tab.push_back(load_row(0, 0, 3, 0));
        dir_tab.push_back(pixel_row(0, 0, 1'b0));
        dir_tab.push_back(pixel_row(1, 0, 1'b0));
        dir_tab.push_back(pixel_row(2, 0, 1'b1));
        dir_tab.push_back(idle_row());
        dir_tab.push_back(load_row(5, 5, 5, 5));
        dir_tab.push_back(idle_row());
        dir_tab.push_back(load_row(1023, 1023, 0, 0));
        dir_tab.push_back(pixel_row(1023, 1023, 1'b0));
        dir_tab.push_back(pixel_row(1022, 1022, 1'b0));
        dir_tab.push_back(load_row(0, 1023, 1023, 0));
        dir_tab.push_back(pixel_row(0, 1023, 1'b0));
        dir_tab.push_back(pixel_row(1, 1022, 1'b0));
        dir_tab.push_back(load_row(10, 0, 13, 1000));
        repeat (3) dir_tab.push_back(step_row());
        dir_tab.push_back(load_row(1000, 7, 0, 9));
        repeat (2) dir_tab.push_back(step_row());
        dir_tab.push_back(load_row(0, 0, 1, 1));
        dir_tab.push_back(pixel_row(0, 0, 1'b1));
        dir_tab.push_back(idle_row());
        foreach (dir_tab[i])
        begin
            v = dir_tab[i];
            send_cmd(v.item, v.typed, v.has_pix, v.pix, live);
        end

        // Random phases, each under its own color and idle pattern
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                c = 24'h000000;
            else if (p == 1)
                c = 24'hFFFFFF;
            else
                c = dda_pkg::color_t'($urandom_range(0, 24'hFFFFFF));
            set_color(c);
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            run_phase(PHASE_ITEMS, p == 2);
        end

        wait_drained();
        if (bad_pixels == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
